// File: src/hdec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdec_pkg
// shared types, sizes and codes of the huffman tree decoder
// ----------------------------------------------------------------------------
package hdec_pkg;

  // table and field sizes
  localparam int NODE_COUNT   = 256;
  localparam int NODE_W       = $clog2(NODE_COUNT);
  localparam int NODE_CNT_W   = $clog2(NODE_COUNT + 1);
  localparam int SUM_W        = NODE_CNT_W + 1;
  localparam int MAX_CODE_LEN = 32;
  localparam int CODE_W       = 32;
  localparam int SEL_W        = $clog2(CODE_W);
  localparam int LEN_W        = 6;
  localparam int SYMBOL_COUNT = 128;
  localparam int SYM_W        = 7;
  localparam int BYTE_W       = 8;
  localparam int VB_W         = 4;
  localparam int CMD_W        = 2;
  localparam int KIND_W       = 2;
  localparam int NODE_ENT_W   = 2 + 2 * NODE_W;

  // commands
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DECODE = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SYM  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD  = 2'd3;

  // one node of the code tree: present[0] left valid, present[1] right valid
  typedef struct packed {
    logic [1:0]        present;
    logic [NODE_W-1:0] right;
    logic [NODE_W-1:0] left;
  } node_t;

  // bit source control and status
  typedef struct packed {
    logic load;
    logic shift;
  } bs_ctl_t;

  typedef struct packed {
    logic             bit_val;
    logic             empty;
    logic [LEN_W-1:0] count;
  } bs_stat_t;

endpackage

// File: src/hdec_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdec_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module hdec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/hdec_bitsrc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdec_bitsrc
// path bit shifter: presents one code or data bit per cycle while shift is held, msb first
// ----------------------------------------------------------------------------
module hdec_bitsrc (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hdec_pkg::bs_ctl_t           ctl,
  input  logic [hdec_pkg::CODE_W-1:0] ld_value,
  input  logic [hdec_pkg::SEL_W-1:0]  ld_sel,
  input  logic [hdec_pkg::LEN_W-1:0]  ld_count,
  output hdec_pkg::bs_stat_t          stat
);

  logic [hdec_pkg::CODE_W-1:0] val_r, val_nxt;
  logic [hdec_pkg::SEL_W-1:0]  sel_r, sel_nxt;
  logic [hdec_pkg::LEN_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    val_nxt = val_r;
    sel_nxt = sel_r;
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      val_nxt = ld_value;
      sel_nxt = ld_sel;
      cnt_nxt = ld_count;
    end else if (ctl.shift) begin
      val_nxt = {val_r[hdec_pkg::CODE_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    sel_r <= sel_nxt;
  end

  // current bit sits at a fixed tap chosen at load time
  assign stat.bit_val = val_r[sel_r];
  assign stat.empty   = (cnt_r == '0);
  assign stat.count   = cnt_r;

endmodule

// File: src/huffman_tree_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_decoder_top
// bit-serial huffman decoder with a loadable code tree
// ----------------------------------------------------------------------------
// clear: result on the cycle after start, busy stays low
// load: code_len taken as at most 32, one node memory read or write per
//   path bit; a full table answers at the first missing branch
// decode: valid_bits taken as at most 8, one node memory read per data bit;
//   a missing branch ends the byte early
// one item at a time; results are strobed and cannot be stalled
// synchronous active-low reset empties the tree and returns the walk to root
// ----------------------------------------------------------------------------
module huffman_tree_decoder_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [hdec_pkg::CMD_W-1:0]   in_cmd,
  input  logic [hdec_pkg::CODE_W-1:0]  in_code_bits,
  input  logic [hdec_pkg::LEN_W-1:0]   in_code_len,
  input  logic [hdec_pkg::SYM_W-1:0]   in_symbol_in,
  input  logic [hdec_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic [hdec_pkg::VB_W-1:0]    in_valid_bits,
  output logic                         out_valid,
  output logic [hdec_pkg::KIND_W-1:0]  out_kind,
  output logic [hdec_pkg::SYM_W-1:0]   out_symbol_out,
  output logic                         out_last
);

  // controller states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_LWALK   = 3'd1;  // load: follow existing nodes
  localparam logic [2:0] ST_LCREATE = 3'd2;  // load: append new nodes
  localparam logic [2:0] ST_DWALK   = 3'd3;  // decode: one data bit a cycle while a branch is taken
  localparam logic [2:0] ST_DEND    = 3'd4;  // decode: flush the held result

  logic [2:0] state_r, state_nxt;

  // tree state
  hdec_pkg::node_t                   root_r, root_nxt;      // root kept in flops
  logic [hdec_pkg::NODE_CNT_W-1:0]   nodes_used_r, nodes_used_nxt;
  logic [hdec_pkg::NODE_W-1:0]       walk_r, walk_nxt;      // carried across bytes

  // per-item working state
  logic [hdec_pkg::NODE_W-1:0]       cur_r, cur_nxt;
  logic                              arrived_r, arrived_nxt;
  logic [hdec_pkg::SYM_W-1:0]        sym_r, sym_nxt;

  // held decode result, so that the final one can carry last
  logic                              pend_v_r, pend_v_nxt;
  logic [hdec_pkg::KIND_W-1:0]       pend_kind_r, pend_kind_nxt;
  logic [hdec_pkg::SYM_W-1:0]        pend_sym_r, pend_sym_nxt;

  // result registers
  logic                              out_valid_r, out_valid_nxt;
  logic [hdec_pkg::KIND_W-1:0]       out_kind_r, out_kind_nxt;
  logic [hdec_pkg::SYM_W-1:0]        out_sym_r, out_sym_nxt;
  logic                              out_last_r, out_last_nxt;

  // memories
  logic                              node_we;
  logic [hdec_pkg::NODE_W-1:0]       node_waddr;
  hdec_pkg::node_t                   node_wdata;
  logic [hdec_pkg::NODE_W-1:0]       rd_addr;
  logic [hdec_pkg::NODE_ENT_W-1:0]   node_rdata;
  logic                              sym_we;
  logic [hdec_pkg::NODE_W-1:0]       sym_waddr;
  logic [hdec_pkg::SYM_W-1:0]        sym_rdata;

  // bit source
  hdec_pkg::bs_ctl_t                 bs_ctl;
  hdec_pkg::bs_stat_t                bs_stat;
  logic [hdec_pkg::CODE_W-1:0]       bs_value;
  logic [hdec_pkg::SEL_W-1:0]        bs_sel;
  logic [hdec_pkg::LEN_W-1:0]        bs_count;

  // helpers
  hdec_pkg::node_t                   ent;        // node under the walk
  hdec_pkg::node_t                   eff;        // node the step leaves from
  logic                              dir;
  logic                              leaf;
  logic                              step_ok;
  logic [hdec_pkg::NODE_W-1:0]       step_child;
  logic [hdec_pkg::NODE_W-1:0]       new_node;
  logic [hdec_pkg::SUM_W-1:0]        need_sum;
  logic [hdec_pkg::LEN_W-1:0]        len_c;
  logic                              res_v;
  logic [hdec_pkg::KIND_W-1:0]       res_kind;
  logic [hdec_pkg::SYM_W-1:0]        res_sym;

  hdec_ram #(
    .WIDTH (hdec_pkg::NODE_ENT_W),
    .DEPTH (hdec_pkg::NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (rd_addr),
    .rdata (node_rdata)
  );

  hdec_ram #(
    .WIDTH (hdec_pkg::SYM_W),
    .DEPTH (hdec_pkg::NODE_COUNT)
  ) u_sym_ram (
    .clk   (clk),
    .we    (sym_we),
    .waddr (sym_waddr),
    .wdata (sym_r),
    .raddr (rd_addr),
    .rdata (sym_rdata)
  );

  hdec_bitsrc u_bitsrc (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (bs_ctl),
    .ld_value (bs_value),
    .ld_sel   (bs_sel),
    .ld_count (bs_count),
    .stat     (bs_stat)
  );

  // the root never comes from memory, so a clear resets its flops and leaves the memories untouched
  assign ent        = (cur_r == '0) ? root_r : hdec_pkg::node_t'(node_rdata);
  assign dir        = bs_stat.bit_val;
  assign leaf       = arrived_r && (ent.present == 2'b00);
  // after a leaf the step starts again from the root in the same cycle
  assign eff        = leaf ? root_r : ent;
  assign step_ok    = eff.present[dir];
  assign step_child = dir ? eff.right : eff.left;
  assign new_node   = nodes_used_r[hdec_pkg::NODE_W-1:0];
  assign need_sum   = hdec_pkg::SUM_W'(nodes_used_r) + hdec_pkg::SUM_W'(bs_stat.count);
  assign len_c      = (in_code_len > hdec_pkg::LEN_W'(hdec_pkg::MAX_CODE_LEN)) ?
                      hdec_pkg::LEN_W'(hdec_pkg::MAX_CODE_LEN) : in_code_len;

  always_comb begin
    state_nxt      = state_r;
    root_nxt       = root_r;
    nodes_used_nxt = nodes_used_r;
    walk_nxt       = walk_r;
    cur_nxt        = cur_r;
    arrived_nxt    = arrived_r;
    sym_nxt        = sym_r;
    pend_v_nxt     = pend_v_r;
    pend_kind_nxt  = pend_kind_r;
    pend_sym_nxt   = pend_sym_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = hdec_pkg::KIND_DONE;
    out_sym_nxt    = '0;
    out_last_nxt   = 1'b0;
    node_we        = 1'b0;
    node_waddr     = cur_r;
    node_wdata     = '0;
    sym_we         = 1'b0;
    sym_waddr      = cur_r;
    rd_addr        = cur_r;
    bs_ctl         = '0;
    bs_value       = in_code_bits;
    bs_sel         = hdec_pkg::SEL_W'(len_c - 1'b1);
    bs_count       = len_c;
    res_v          = 1'b0;
    res_kind       = hdec_pkg::KIND_SYM;
    res_sym        = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_cmd)
            hdec_pkg::CMD_CLEAR: begin
              root_nxt       = '0;
              nodes_used_nxt = hdec_pkg::NODE_CNT_W'(1);
              walk_nxt       = '0;
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = hdec_pkg::KIND_DONE;
              out_last_nxt   = 1'b1;
            end
            hdec_pkg::CMD_LOAD: begin
              bs_ctl.load = 1'b1;
              if ({1'b0, in_symbol_in} >= (hdec_pkg::SYM_W + 1)'(hdec_pkg::SYMBOL_COUNT)) begin
                sym_nxt = hdec_pkg::SYM_W'(hdec_pkg::SYMBOL_COUNT - 1);
              end else begin
                sym_nxt = in_symbol_in;
              end
              cur_nxt     = '0;
              arrived_nxt = 1'b0;
              state_nxt   = ST_LWALK;
            end
            hdec_pkg::CMD_DECODE: begin
              bs_ctl.load = 1'b1;
              bs_value    = hdec_pkg::CODE_W'(in_data_byte);
              bs_sel      = hdec_pkg::SEL_W'(hdec_pkg::BYTE_W - 1);
              if (in_valid_bits > hdec_pkg::VB_W'(hdec_pkg::BYTE_W)) begin
                bs_count = hdec_pkg::LEN_W'(hdec_pkg::BYTE_W);
              end else begin
                bs_count = hdec_pkg::LEN_W'(in_valid_bits);
              end
              cur_nxt     = walk_r;
              rd_addr     = walk_r;
              arrived_nxt = 1'b0;
              pend_v_nxt  = 1'b0;
              state_nxt   = ST_DWALK;
            end
            default: begin
            end
          endcase
        end
      end

      ST_LWALK: begin
        if (bs_stat.empty) begin
          // path ends on an existing node: just relabel it
          sym_we        = 1'b1;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = hdec_pkg::KIND_DONE;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (ent.present[dir]) begin
          cur_nxt      = dir ? ent.right : ent.left;
          rd_addr      = cur_nxt;
          bs_ctl.shift = 1'b1;
        end else if (need_sum > hdec_pkg::SUM_W'(hdec_pkg::NODE_COUNT)) begin
          // not enough free nodes: nothing is changed
          out_valid_nxt = 1'b1;
          out_kind_nxt  = hdec_pkg::KIND_FULL;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          // hang the first new node below the current one
          node_we = 1'b1;
          node_wdata = ent;
          node_wdata.present[dir] = 1'b1;
          if (dir) begin
            node_wdata.right = new_node;
          end else begin
            node_wdata.left = new_node;
          end
          bs_ctl.shift = 1'b1;
          state_nxt    = ST_LCREATE;
        end
      end

      ST_LCREATE: begin
        node_we        = 1'b1;
        node_waddr     = new_node;
        nodes_used_nxt = nodes_used_r + 1'b1;
        if (bs_stat.empty) begin
          node_wdata    = '0;
          sym_we        = 1'b1;
          sym_waddr     = new_node;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = hdec_pkg::KIND_DONE;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          node_wdata = '0;
          node_wdata.present[dir] = 1'b1;
          if (dir) begin
            node_wdata.right = new_node + 1'b1;
          end else begin
            node_wdata.left = new_node + 1'b1;
          end
          bs_ctl.shift = 1'b1;
        end
      end

      ST_DWALK: begin
        if (leaf) begin
          res_v    = 1'b1;
          res_kind = hdec_pkg::KIND_SYM;
          res_sym  = sym_rdata;
        end
        if (bs_stat.empty) begin
          cur_nxt     = leaf ? '0 : cur_r;
          arrived_nxt = 1'b0;
          state_nxt   = ST_DEND;
        end else if (step_ok) begin
          cur_nxt      = step_child;
          rd_addr      = step_child;
          arrived_nxt  = 1'b1;
          bs_ctl.shift = 1'b1;
        end else if (leaf) begin
          // leaf and a missing root branch in one cycle: take the leaf now
          cur_nxt     = '0;
          arrived_nxt = 1'b0;
        end else begin
          res_v       = 1'b1;
          res_kind    = hdec_pkg::KIND_BAD;
          cur_nxt     = '0;
          arrived_nxt = 1'b0;
          state_nxt   = ST_DEND;
        end
        if (res_v) begin
          out_valid_nxt = pend_v_r;
          out_kind_nxt  = pend_kind_r;
          out_sym_nxt   = pend_sym_r;
          pend_v_nxt    = 1'b1;
          pend_kind_nxt = res_kind;
          pend_sym_nxt  = res_sym;
        end
      end

      ST_DEND: begin
        walk_nxt      = cur_r;
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        if (pend_v_r) begin
          out_kind_nxt = pend_kind_r;
          out_sym_nxt  = pend_sym_r;
        end else begin
          out_kind_nxt = hdec_pkg::KIND_DONE;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // keep the root copy in step with writes to node zero
    if (node_we && (node_waddr == '0)) begin
      root_nxt = node_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      root_r       <= '0;
      nodes_used_r <= hdec_pkg::NODE_CNT_W'(1);
      walk_r       <= '0;
      cur_r        <= '0;
      arrived_r    <= 1'b0;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      root_r       <= root_nxt;
      nodes_used_r <= nodes_used_nxt;
      walk_r       <= walk_nxt;
      cur_r        <= cur_nxt;
      arrived_r    <= arrived_nxt;
      pend_v_r     <= pend_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sym_r       <= sym_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_sym_r  <= pend_sym_nxt;
    out_kind_r  <= out_kind_nxt;
    out_sym_r   <= out_sym_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_symbol_out = out_sym_r;
  assign out_last       = out_last_r;

endmodule

// File: src/hdec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdec_checker
// port-level checks of the huffman tree decoder
// ----------------------------------------------------------------------------
module hdec_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [hdec_pkg::CMD_W-1:0]  in_cmd,
  input logic                        out_valid,
  input logic [hdec_pkg::KIND_W-1:0] out_kind,
  input logic [hdec_pkg::SYM_W-1:0]  out_symbol_out,
  input logic                        out_last
);

  // only decoded symbols carry a symbol value
  a_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != hdec_pkg::KIND_SYM) |-> (out_symbol_out == '0))
    else $error("non-symbol result with a symbol value");

  // done, full and bad path always close an item
  a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != hdec_pkg::KIND_SYM) |-> out_last)
    else $error("closing result kind without last");

  // clear answers on the next cycle
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_cmd == hdec_pkg::CMD_CLEAR) |=>
      out_valid && (out_kind == hdec_pkg::KIND_DONE) && out_last)
    else $error("clear not answered");

  // the last result coincides with the return to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("last result while still busy");

  // an earlier result of a decode leaves the block busy
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("intermediate result while idle");

endmodule

bind huffman_tree_decoder_top hdec_checker u_hdec_checker (.*);

// File: tb/huffman_tree_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_decoder_checker
// watches both channels of the huffman tree decoder, keeps its own copy of the
// code tree and walk, predicts every result and compares it field by field
// ----------------------------------------------------------------------------
module huffman_tree_decoder_checker
  import hdec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [CODE_W-1:0] in_code_bits,
  input  logic [LEN_W-1:0]  in_code_len,
  input  logic [SYM_W-1:0]  in_symbol_in,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [VB_W-1:0]   in_valid_bits,
  input  logic              out_valid,
  input  logic [KIND_W-1:0] out_kind,
  input  logic [SYM_W-1:0]  out_symbol_out,
  input  logic              out_last,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  sym;
    logic              last;
  } result_t;

  node_t             tree [NODE_COUNT];
  logic [SYM_W-1:0]  leaf_sym [NODE_COUNT];
  int                nodes_used;
  logic [NODE_W-1:0] walk_at;
  result_t           due_results [$];
  int                err_count;

  function automatic logic [NODE_W-1:0] child_of(input logic [NODE_W-1:0] n, input logic d);
    return d ? tree[n].right : tree[n].left;
  endfunction

  task automatic add_result(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                            input logic last);
    result_t r;
    r.kind = kind;
    r.sym  = sym;
    r.last = last;
    due_results = {due_results, r};
  endtask

  task automatic empty_tree();
    for (int n = 0; n < NODE_COUNT; n++) tree[n].present = 2'b00;
    nodes_used = 1;
    walk_at    = '0;
  endtask

  task automatic load_code(input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len_in,
                           input logic [SYM_W-1:0] sym_in);
    int                len;
    int                needed;
    logic [NODE_W-1:0] n;
    logic              d;
    logic [SYM_W-1:0]  sym;
    len    = (len_in > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(len_in);
    sym    = (sym_in >= SYMBOL_COUNT) ? SYM_W'(SYMBOL_COUNT - 1) : sym_in;
    n      = '0;
    needed = 0;
    // first pass only counts the nodes still to be made
    for (int i = 0; i < len; i++) begin
      d = code[len-1-i];
      if (!tree[n].present[d]) begin
        needed = len - i;
        break;
      end
      n = child_of(n, d);
    end
    if (nodes_used + needed > NODE_COUNT) begin
      add_result(KIND_FULL, '0, 1'b1);
      return;
    end
    n = '0;
    for (int i = 0; i < len; i++) begin
      d = code[len-1-i];
      if (!tree[n].present[d]) begin
        tree[nodes_used]     = '0;
        leaf_sym[nodes_used] = '0;
        if (d) tree[n].right = NODE_W'(nodes_used);
        else   tree[n].left  = NODE_W'(nodes_used);
        tree[n].present[d] = 1'b1;
        nodes_used++;
      end
      n = child_of(n, d);
    end
    leaf_sym[n] = sym;
    add_result(KIND_DONE, '0, 1'b1);
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] data, input logic [VB_W-1:0] vb);
    int                nbits;
    int                emitted;
    logic              d;
    logic [NODE_W-1:0] c;
    nbits   = (vb > 8) ? 8 : int'(vb);
    emitted = 0;
    for (int i = 0; i < nbits; i++) begin
      d = data[7-i];
      if (!tree[walk_at].present[d]) begin
        // missing branch: back to the root, rest of the byte dropped
        walk_at = '0;
        add_result(KIND_BAD, '0, 1'b0);
        emitted++;
        break;
      end
      c = child_of(walk_at, d);
      if (tree[c].present == 2'b00) begin
        add_result(KIND_SYM, leaf_sym[c], 1'b0);
        emitted++;
        walk_at = '0;
      end else begin
        walk_at = c;
      end
    end
    if (emitted == 0) begin
      add_result(KIND_DONE, '0, 1'b1);
    end else begin
      due_results[due_results.size() - 1].last = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      for (int n = 0; n < NODE_COUNT; n++) begin
        tree[n]     = '0;
        leaf_sym[n] = '0;
      end
      empty_tree();
      due_results.delete();
    end else begin
      // results first: a result always belongs to an earlier item
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result kind %0d symbol %0d last %0b",
                   $time, out_kind, out_symbol_out, out_last);
          err_count++;
        end else begin
          want = due_results.pop_front();
          if (out_kind !== want.kind) begin
            $display("%0t: kind mismatch, expected %0d actual %0d", $time, want.kind, out_kind);
            err_count++;
          end
          if (out_symbol_out !== want.sym) begin
            $display("%0t: symbol mismatch, expected %0d actual %0d",
                     $time, want.sym, out_symbol_out);
            err_count++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last mismatch, expected %0b actual %0b", $time, want.last, out_last);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        case (in_cmd)
          CMD_CLEAR: begin
            empty_tree();
            add_result(KIND_DONE, '0, 1'b1);
          end
          CMD_LOAD:   load_code(in_code_bits, in_code_len, in_symbol_in);
          CMD_DECODE: decode_byte(in_data_byte, in_valid_bits);
          default: ;
        endcase
      end
    end
    errors  <= err_count;
    pending <= due_results.size();
  end

endmodule

// File: tb/tb_huffman_tree_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_tree_decoder_top
// drives clear, load and decode commands into the huffman tree decoder: a
// directed opening on the corner cases, then random complete code trees
// with random byte streams mixed with random noise, under varying idle rates
// ----------------------------------------------------------------------------
module tb_huffman_tree_decoder_top;
  import hdec_pkg::*;

  localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake before giving up
  localparam int RANDOM_ITEMS = 70;    // with the directed opening at least 97 items in all
  localparam int DRAIN_CYCLES = 60;    // longest load plus margin

  // cmd 3 is not a command: the block accepts it and stays silent
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [SYM_W-1:0]  sym;
    logic [BYTE_W-1:0] data;
    logic [VB_W-1:0]   vb;
  } item_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  in_cmd;
  logic [CODE_W-1:0] in_code_bits;
  logic [LEN_W-1:0]  in_code_len;
  logic [SYM_W-1:0]  in_symbol_in;
  logic [BYTE_W-1:0] in_data_byte;
  logic [VB_W-1:0]   in_valid_bits;
  logic              out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [SYM_W-1:0]  out_symbol_out;
  logic              out_last;

  int errors;
  int pending;
  int idle_pct;
  int idle_cycles;
  int n_work;
  int cmd_seen [4];
  int kind_seen [4];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  huffman_tree_decoder_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_code_bits   (in_code_bits),
    .in_code_len    (in_code_len),
    .in_symbol_in   (in_symbol_in),
    .in_data_byte   (in_data_byte),
    .in_valid_bits  (in_valid_bits),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_symbol_out (out_symbol_out),
    .out_last       (out_last)
  );

  huffman_tree_decoder_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_code_bits   (in_code_bits),
    .in_code_len    (in_code_len),
    .in_symbol_in   (in_symbol_in),
    .in_data_byte   (in_data_byte),
    .in_valid_bits  (in_valid_bits),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_symbol_out (out_symbol_out),
    .out_last       (out_last),
    .errors         (errors),
    .pending        (pending)
  );

  // watchdog: any stretch without a handshake on either side ends the run
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, pending);
      $display("huffman_tree_decoder_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // tally of result kinds for the summary
  always @(posedge clk) begin
    if (rst_n && out_valid) kind_seen[out_kind]++;
  end

  // every field random, so fields a command ignores still toggle
  function automatic item_t rand_item();
    item_t it;
    it.cmd  = CMD_W'($urandom_range(0, 3));
    it.code = $urandom;
    it.len  = LEN_W'($urandom_range(0, 63));
    it.sym  = SYM_W'($urandom_range(0, 127));
    it.data = BYTE_W'($urandom_range(0, 255));
    it.vb   = VB_W'($urandom_range(0, 15));
    return it;
  endfunction

  function automatic item_t mk_clear();
    item_t it;
    it     = rand_item();
    it.cmd = CMD_CLEAR;
    return it;
  endfunction

  function automatic item_t mk_load(input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                                    input logic [SYM_W-1:0] sym);
    item_t it;
    it      = rand_item();
    it.cmd  = CMD_LOAD;
    it.code = code;
    it.len  = len;
    it.sym  = sym;
    return it;
  endfunction

  function automatic item_t mk_decode(input logic [BYTE_W-1:0] data, input logic [VB_W-1:0] vb);
    item_t it;
    it      = rand_item();
    it.cmd  = CMD_DECODE;
    it.data = data;
    it.vb   = vb;
    return it;
  endfunction

  // present one item and hold it until the block takes it; returns on the
  // accepting edge so the next item can follow without a gap
  task automatic send(input item_t it);
    start         <= 1'b1;
    in_cmd        <= it.cmd;
    in_code_bits  <= it.code;
    in_code_len   <= it.len;
    in_symbol_in  <= it.sym;
    in_data_byte  <= it.data;
    in_valid_bits <= it.vb;
    @(posedge clk);
    while (busy) @(posedge clk);
    cmd_seen[it.cmd]++;
    if (it.cmd != CMD_NONE) n_work++;
  endtask

  // random idle cycles at the current rate, then the item
  task automatic issue(input item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    send(it);
  endtask

  // sender holds off until every predicted result has been seen
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    item_t             it;
    logic [CODE_W-1:0] first_code;
    logic [CODE_W-1:0] cw_bits [$];
    int                cw_len [$];
    logic [CODE_W-1:0] split_code;
    int                split_len;
    int                pick;
    int                target;
    int                round;
    int                directed_work;

    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_cmd        <= CMD_CLEAR;
    in_code_bits  <= '0;
    in_code_len   <= '0;
    in_symbol_in  <= '0;
    in_data_byte  <= '0;
    in_valid_bits <= '0;
    idle_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed opening, back to back ----
    // empty tree: first step already misses
    issue(mk_decode(8'hA5, 4'd8));
    // no valid bits: nothing walked, plain done
    issue(mk_decode(8'hFF, 4'd0));
    // small complete tree: 0 -> 'A', 10 -> 0, 11 -> 127
    issue(mk_load(32'h0, 6'd1, 7'h41));
    issue(mk_load(32'h2, 6'd2, 7'h00));
    issue(mk_load(32'h3, 6'd2, 7'h7F));
    issue(mk_decode(8'hFF, 4'd8));   // four top symbols
    issue(mk_decode(8'h00, 4'd8));   // eight results, the most one byte can give
    issue(mk_decode(8'hB0, 4'd3));   // ends mid-code, walk carries over
    issue(mk_decode(8'h80, 4'd12));  // finishes the carried code, count above 8 clamps
    // load through an existing leaf, which then stops being a leaf
    issue(mk_load(32'h1, 6'd2, 7'h05));
    issue(mk_decode(8'h00, 4'd8));   // 00 now missing: bad path
    // load ending on an inner node only replaces its symbol
    issue(mk_load(32'h0, 6'd1, 7'h09));
    // zero length lands on the root
    issue(mk_load(32'h0, 6'd0, 7'h03));
    // length above the maximum, all ones
    issue(mk_load(32'hFFFF_FFFF, 6'd63, 7'h01));
    issue(mk_decode(8'hFF, 4'd8));   // deep path, no leaf reached
    it     = rand_item();
    it.cmd = CMD_NONE;
    issue(it);
    issue(mk_clear());
    // fill the table: distinct three-bit prefixes keep each long code mostly new
    for (int i = 0; i < 8; i++) begin
      it = mk_load({i[2:0], 29'($urandom)}, 6'd32, SYM_W'($urandom_range(0, 127)));
      if (i == 0) first_code = it.code;
      issue(it);
    end
    // branching off early needs far more nodes than remain
    issue(mk_load(first_code ^ 32'h0200_0000, 6'd32, 7'h11));
    // an existing path needs none, so it still loads
    issue(mk_load(first_code, 6'd32, 7'h22));
    issue(mk_clear());
    directed_work = n_work;

    // ---- random part ----
    round = 0;
    while (n_work - directed_work < RANDOM_ITEMS) begin
      case (round % 4)
        0:       idle_pct = 0;
        1:       idle_pct = 76;
        2:       idle_pct = 13;
        default: idle_pct = 0;
      endcase
      if ($urandom_range(0, 3) != 0) begin
        // well-formed: fresh complete prefix code, then a stream of bytes
        wait_drained();
        issue(mk_clear());
        cw_bits.delete();
        cw_len.delete();
        cw_bits = {cw_bits, 32'd0};
        cw_len  = {cw_len, 1};
        cw_bits = {cw_bits, 32'd1};
        cw_len  = {cw_len, 1};
        target = $urandom_range(2, 12);
        // split random leaves until the code has enough symbols
        while (cw_bits.size() < target) begin
          pick = $urandom_range(0, cw_bits.size() - 1);
          if (cw_len[pick] < 8) begin
            split_code = {cw_bits[pick][CODE_W-2:0], 1'b1};
            split_len  = cw_len[pick] + 1;
            cw_bits = {cw_bits, split_code};
            cw_len  = {cw_len, split_len};
            cw_bits[pick] = cw_bits[pick] << 1;
            cw_len[pick]  = cw_len[pick] + 1;
          end
        end
        foreach (cw_bits[j])
          issue(mk_load(cw_bits[j], LEN_W'(cw_len[j]), SYM_W'($urandom_range(0, 127))));
        repeat ($urandom_range(3, 10))
          issue(mk_decode(BYTE_W'($urandom_range(0, 255)),
                          ($urandom_range(0, 3) != 0) ? 4'd8 : VB_W'($urandom_range(0, 15))));
      end else begin
        // noise: anything at all, on top of whatever tree is loaded
        repeat ($urandom_range(1, 4)) issue(rand_item());
      end
      round++;
    end

    // ---- drain and verdict ----
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d items taken: %0d clear, %0d load, %0d decode, %0d ignored",
             cmd_seen[CMD_CLEAR] + cmd_seen[CMD_LOAD] + cmd_seen[CMD_DECODE] + cmd_seen[CMD_NONE],
             cmd_seen[CMD_CLEAR], cmd_seen[CMD_LOAD], cmd_seen[CMD_DECODE], cmd_seen[CMD_NONE]);
    $display("summary: results seen: %0d symbols, %0d done, %0d table full, %0d bad path",
             kind_seen[KIND_SYM], kind_seen[KIND_DONE], kind_seen[KIND_FULL], kind_seen[KIND_BAD]);
    if (errors == 0) begin
      $display("huffman_tree_decoder_top verification clean");
    end else begin
      $display("huffman_tree_decoder_top verification failed");
    end
    $finish;
  end

endmodule
